>>> rtl/core/dri_pkg.sv
// Shared constants, register indexes and the lane control struct for the
// dead-reckoning integrator. No dependencies.
package dri_pkg;

  localparam int NUM_AXES   = 3;
  localparam int ACCEL_W    = 16;
  localparam int POS_W      = 48;
  localparam int TS_W       = 25;
  localparam int DZ_W       = 15;
  localparam int LIM_W      = 8;
  localparam int RUN_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // time_step has 24 fractional bits; the trapezoid halving adds one more
  localparam int TRAP_SH = 25;
  // low slice of the velocity sum fed to the position multiplier
  localparam int LO_W = 32;

  localparam int FRAC_BITS_DEF   = 24;
  localparam int STATE_WIDTH_DEF = 48;

  localparam logic [TS_W-1:0]  TS_RST   = TS_W'(167772);
  localparam logic [DZ_W-1:0]  DZ_X_RST = DZ_W'(10);
  localparam logic [DZ_W-1:0]  DZ_Y_RST = DZ_W'(12);
  localparam logic [DZ_W-1:0]  DZ_Z_RST = DZ_W'(14);
  localparam logic [LIM_W-1:0] LIM_RST  = LIM_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_LIM  = 3'd4;

  // one strobe per step of the lane datapath
  typedef struct packed {
    logic load;    // capture sample, apply deadzone
    logic mul;     // acceleration sum times time step
    logic vel;     // new velocity, saturated
    logic vsum;    // velocity sum for the position step
    logic pmul;    // velocity sum times time step
    logic dp;      // position increment
    logic commit;  // update state, present result
  } lane_ctrl_t;

endpackage

>>> rtl/core/dri_if.sv
// Valid/ready channel interfaces for the dead-reckoning integrator:
// acceleration samples in, positions and still flags out. Uses dri_pkg.
interface dri_in_if;
  import dri_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
  modport mon    (input valid, input accel_x, input accel_y, input accel_z, input ready);
endinterface

interface dri_out_if;
  import dri_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    still_x;
  logic                    still_y;
  logic                    still_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output still_x, output still_y, output still_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input still_x, input still_y, input still_z, output ready);
  modport mon    (input valid, input pos_x, input pos_y, input pos_z,
                  input still_x, input still_y, input still_z, input ready);
endinterface

>>> rtl/core/dri_lane.sv
// One axis of the integrator: deadzone, trapezoid velocity and position
// steps, zero-run counter and velocity clear. Uses dri_pkg.
module dri_lane #(
  parameter int FRAC_BITS   = dri_pkg::FRAC_BITS_DEF,
  parameter int STATE_WIDTH = dri_pkg::STATE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dri_pkg::lane_ctrl_t                ctrl,
  input  logic signed [dri_pkg::ACCEL_W-1:0] accel,
  input  logic [dri_pkg::TS_W-1:0]           time_step,
  input  logic [dri_pkg::DZ_W-1:0]           deadzone,
  input  logic [dri_pkg::LIM_W-1:0]          still_limit,
  output logic signed [STATE_WIDTH-1:0]      pos,
  output logic                               still
);
  import dri_pkg::*;

  localparam int SW     = STATE_WIDTH;
  localparam int AS_W   = ACCEL_W + 1;
  localparam int TSS_W  = TS_W + 1;
  localparam int PA_W   = AS_W + TSS_W;
  localparam int UP_SH  = (FRAC_BITS >= TRAP_SH) ? FRAC_BITS - TRAP_SH : 0;
  localparam int DN_SH  = (FRAC_BITS < TRAP_SH) ? TRAP_SH - FRAC_BITS : 0;
  localparam int DV_W   = PA_W + UP_SH;
  localparam int VW_W   = ((DV_W > SW) ? DV_W : SW) + 1;
  localparam int HI_W   = SW + 1 - LO_W;
  localparam int LO_PW  = LO_W + TS_W;
  localparam int HI_PW  = HI_W + TSS_W;
  localparam int PW     = SW + 1 + TSS_W;
  localparam int DP_W   = PW - TRAP_SH;
  localparam int PS_W   = ((DP_W > SW) ? DP_W : SW) + 1;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [RUN_W-1:0]     RUN_MAX = {RUN_W{1'b1}};

  logic signed [ACCEL_W-1:0] a_r, last_a_r;
  logic signed [PA_W-1:0]    pa_r;
  logic signed [SW-1:0]      v_new_r, last_v_r, last_p_r;
  logic signed [SW:0]        vsum_r;
  logic [LO_PW-1:0]          plo_r;
  logic signed [HI_PW-1:0]   phi_r;
  logic signed [DP_W-1:0]    dp_r;
  logic [RUN_W-1:0]          run_r;

  logic [AS_W-1:0]           mag;
  logic signed [ACCEL_W-1:0] a_dz;
  logic signed [AS_W-1:0]    asum;
  logic signed [TSS_W-1:0]   ts_s;
  logic signed [PA_W-1:0]    pa_nxt;
  logic signed [DV_W-1:0]    dv_ext, dv;
  logic signed [VW_W-1:0]    vw;
  logic [VW_W-SW:0]          vw_hi;
  logic signed [SW-1:0]      v_sat;
  logic signed [HI_W-1:0]    vs_hi;
  logic signed [PW-1:0]      full;
  logic signed [PS_W-1:0]    pw;
  logic [PS_W-SW:0]          pw_hi;
  logic signed [SW-1:0]      p_new;
  logic [RUN_W-1:0]          run_nxt;

  // deadzone: magnitude at or below the threshold counts as zero
  assign mag  = accel[ACCEL_W-1] ? (AS_W'(0) - AS_W'(accel)) : AS_W'(accel);
  assign a_dz = (mag <= AS_W'(deadzone)) ? '0 : accel;

  assign ts_s   = $signed({1'b0, time_step});
  assign asum   = AS_W'(a_r) + AS_W'(last_a_r);
  assign pa_nxt = PA_W'(asum) * PA_W'(ts_s);

  // velocity step, floor shift into the state format, then saturate
  assign dv_ext = DV_W'(pa_r);
  assign dv     = (dv_ext <<< UP_SH) >>> DN_SH;
  assign vw     = VW_W'(last_v_r) + VW_W'(dv);
  assign vw_hi  = vw[VW_W-1:SW-1];
  assign v_sat  = ((&vw_hi) || !(|vw_hi)) ? vw[SW-1:0] : (vw[VW_W-1] ? S_MIN : S_MAX);

  // position step: split product, recombine, floor shift, saturate
  assign vs_hi = vsum_r[SW:LO_W];
  assign full  = (PW'(phi_r) <<< LO_W) + $signed(PW'(plo_r));
  assign pw    = PS_W'(last_p_r) + PS_W'(dp_r);
  assign pw_hi = pw[PS_W-1:SW-1];
  assign p_new = ((&pw_hi) || !(|pw_hi)) ? pw[SW-1:0] : (pw[PS_W-1] ? S_MIN : S_MAX);

  assign run_nxt = (a_r == '0) ? ((run_r == RUN_MAX) ? RUN_MAX : run_r + RUN_W'(1)) : '0;
  assign still   = (run_nxt >= still_limit);
  assign pos     = p_new;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= a_dz;
    end
    if (ctrl.mul) begin
      pa_r <= pa_nxt;
    end
    if (ctrl.vel) begin
      v_new_r <= v_sat;
    end
    if (ctrl.vsum) begin
      vsum_r <= (SW+1)'(v_new_r) + (SW+1)'(last_v_r);
    end
    if (ctrl.pmul) begin
      plo_r <= LO_PW'(vsum_r[LO_W-1:0]) * LO_PW'(time_step);
      phi_r <= HI_PW'(vs_hi) * HI_PW'(ts_s);
    end
    if (ctrl.dp) begin
      dp_r <= full[PW-1:TRAP_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r <= '0;
      last_v_r <= '0;
      last_p_r <= '0;
      run_r    <= '0;
    end else if (ctrl.commit) begin
      last_a_r <= a_r;
      last_v_r <= still ? '0 : v_new_r;
      last_p_r <= p_new;
      run_r    <= run_nxt;
    end
  end

endmodule

>>> rtl/core/dri_merge.sv
// Merge stage: gathers the three lane results into the output register,
// fits positions to the output width and holds them until transfer. Uses dri_pkg.
module dri_merge #(
  parameter int STATE_WIDTH = dri_pkg::STATE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             commit,
  input  logic signed [STATE_WIDTH-1:0]    pos_in [dri_pkg::NUM_AXES],
  input  logic [dri_pkg::NUM_AXES-1:0]     still_in,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [dri_pkg::POS_W-1:0] out_pos [dri_pkg::NUM_AXES],
  output logic [dri_pkg::NUM_AXES-1:0]     out_still,
  output logic                             free
);
  import dri_pkg::*;

  localparam int EW = (STATE_WIDTH > POS_W) ? STATE_WIDTH : POS_W;
  localparam logic signed [POS_W-1:0] O_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] O_MIN = {1'b1, {(POS_W-1){1'b0}}};

  logic                    valid_r;
  logic signed [POS_W-1:0] pos_r [NUM_AXES];
  logic [NUM_AXES-1:0]     still_r;
  logic signed [POS_W-1:0] pos_fit [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_fit
    logic signed [EW-1:0] ext;
    logic [EW-POS_W:0]    hi;
    assign ext        = EW'(pos_in[i]);
    assign hi         = ext[EW-1:POS_W-1];
    assign pos_fit[i] = ((&hi) || !(|hi)) ? ext[POS_W-1:0] : (ext[EW-1] ? O_MIN : O_MAX);
  end

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (commit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pos_r   <= pos_fit;
      still_r <= still_in;
    end
  end

  assign out_valid = valid_r;
  assign out_pos   = pos_r;
  assign out_still = still_r;

endmodule

>>> rtl/core/imu_dead_reckoning_integrator.sv
// Three-axis IMU dead-reckoning integrator, top level. Depends on dri_pkg,
// dri_if, dri_lane and dri_merge. Each transfer on in_chan carries one
// acceleration sample per axis (0.01 m/s^2 per count). Three identical lanes,
// one per axis, apply the axis deadzone, integrate velocity and position with
// the trapezoid rule over time_step (2^-24 s units), count consecutive zero
// samples (saturating at 255) and clear the axis velocity once that count
// reaches still_limit; the merge stage registers the three positions,
// saturated to 48 bits, with the still flags and holds them on out_chan until
// transferred. Velocity and position keep FRAC_BITS fractional bits in
// STATE_WIDTH-bit state. One item is in flight at a time: a sample is taken
// only while the sequencer is idle, and the next one is not taken until this
// one has been stepped through the lane datapath sequence (sum times step,
// velocity saturate, velocity sum, split position multiply, increment,
// commit) and its result is registered. A result waiting on out_chan does
// not block the next sample; only the commit step waits for the output
// register to free. Configuration writes on cfg_we/cfg_idx/cfg_data take
// effect at once; index 0 is time_step, 1..3 the x/y/z deadzones, 4
// still_limit; other indexes are ignored and wide data is truncated. Write
// configuration only while no item is in flight.
module imu_dead_reckoning_integrator #(
  parameter int FRAC_BITS   = dri_pkg::FRAC_BITS_DEF,
  parameter int STATE_WIDTH = dri_pkg::STATE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dri_in_if.sink                            in_chan,
  dri_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [dri_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [dri_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dri_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_VEL    = 7'b0000100,
    S_VSUM   = 7'b0001000,
    S_PMUL   = 7'b0010000,
    S_DP     = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  lane_ctrl_t              ctrl;
  logic                    in_xfer;
  logic                    out_free;

  logic [TS_W-1:0]         ts_r;
  logic [DZ_W-1:0]         dz_r [NUM_AXES];
  logic [LIM_W-1:0]        lim_r;

  logic signed [ACCEL_W-1:0]     accel [NUM_AXES];
  logic signed [STATE_WIDTH-1:0] lane_pos [NUM_AXES];
  logic [NUM_AXES-1:0]           lane_still;
  logic signed [POS_W-1:0]       out_pos [NUM_AXES];
  logic [NUM_AXES-1:0]           out_still;
  logic                          out_valid;

  // Configuration registers: decode the index, truncate wide data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= TS_RST;
      dz_r[0] <= DZ_X_RST;
      dz_r[1] <= DZ_Y_RST;
      dz_r[2] <= DZ_Z_RST;
      lim_r   <= LIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TIME_STEP:  ts_r    <= cfg_data[TS_W-1:0];
        REG_DEADZONE_X: dz_r[0] <= cfg_data[DZ_W-1:0];
        REG_DEADZONE_Y: dz_r[1] <= cfg_data[DZ_W-1:0];
        REG_DEADZONE_Z: dz_r[2] <= cfg_data[DZ_W-1:0];
        REG_STILL_LIM:  lim_r   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: walk each accepted sample through the lane steps
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_VEL;
      S_VEL:    state_nxt = S_VSUM;
      S_VSUM:   state_nxt = S_PMUL;
      S_PMUL:   state_nxt = S_DP;
      S_DP:     state_nxt = S_COMMIT;
      // hold until the output register can take the result
      S_COMMIT: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctrl.load   = in_xfer;
    ctrl.mul    = (state_r == S_MUL);
    ctrl.vel    = (state_r == S_VEL);
    ctrl.vsum   = (state_r == S_VSUM);
    ctrl.pmul   = (state_r == S_PMUL);
    ctrl.dp     = (state_r == S_DP);
    ctrl.commit = (state_r == S_COMMIT) && out_free;
  end

  assign accel[0] = in_chan.accel_x;
  assign accel[1] = in_chan.accel_y;
  assign accel[2] = in_chan.accel_z;

  // One lane per axis, all stepped by the same strobes
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    dri_lane #(
      .FRAC_BITS   (FRAC_BITS),
      .STATE_WIDTH (STATE_WIDTH)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .accel       (accel[i]),
      .time_step   (ts_r),
      .deadzone    (dz_r[i]),
      .still_limit (lim_r),
      .pos         (lane_pos[i]),
      .still       (lane_still[i])
    );
  end

  dri_merge #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .commit    (ctrl.commit),
    .pos_in    (lane_pos),
    .still_in  (lane_still),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_pos   (out_pos),
    .out_still (out_still),
    .free      (out_free)
  );

  assign out_chan.valid   = out_valid;
  assign out_chan.pos_x   = out_pos[0];
  assign out_chan.pos_y   = out_pos[1];
  assign out_chan.pos_z   = out_pos[2];
  assign out_chan.still_x = out_still[0];
  assign out_chan.still_y = out_still[1];
  assign out_chan.still_z = out_still[2];

endmodule

>>> rtl/core/dri_checker.sv
// Port-level checks for the dead-reckoning integrator, bound to the top
// level. Depends on dri_pkg and imu_dead_reckoning_integrator.
module dri_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [dri_pkg::POS_W-1:0] out_pos_x,
  input logic signed [dri_pkg::POS_W-1:0] out_pos_y,
  input logic signed [dri_pkg::POS_W-1:0] out_pos_z,
  input logic                             out_still_x,
  input logic                             out_still_y,
  input logic                             out_still_z
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one sample in flight: ready drops after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("sample taken while another is in flight");

  // a result never appears the cycle after its sample
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pos_z) &&
      $stable(out_still_x) && $stable(out_still_y) && $stable(out_still_z))
    else $error("stalled result payload changed");

endmodule

bind imu_dead_reckoning_integrator dri_checker u_dri_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_pos_x   (out_chan.pos_x),
  .out_pos_y   (out_chan.pos_y),
  .out_pos_z   (out_chan.pos_z),
  .out_still_x (out_chan.still_x),
  .out_still_y (out_chan.still_y),
  .out_still_z (out_chan.still_z)
);
